/* rtl/core/smm_pkg.sv */
// shared constants, codes and types for the sorted merge median block
package smm_pkg;

   localparam int LIST_DEPTH = 1024;
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int TOT_W      = CNT_W + 1;
   localparam int VALUE_W    = 32;
   localparam int MED_W      = VALUE_W + 1;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;

   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] first_count;
      logic [CNT_W-1:0] second_count;
      logic [CNT_W-1:0] lo_pos;
      logic [CNT_W-1:0] hi_pos;
   } walk_cmd_type;

   typedef struct packed {
      logic                      done;
      logic signed [VALUE_W-1:0] lo;
      logic signed [VALUE_W-1:0] hi;
   } walk_rsp_type;

endpackage

/* rtl/core/sorted_merge_median.sv */
// appends run one beat per cycle while no walk runs; a query answers when its merge walk finishes
// the query time is set by the merge walk, one element per cycle through the read ports
// an empty or dropped query answers from a register in the cycle after its beat
// no beat is taken while a walk runs, nor a query while a result waits
// reset clears both counts and the drop flag; list memories are not cleared
module sorted_merge_median (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [smm_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [smm_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [smm_pkg::MED_W-1:0]   rsp_median_twice,
   output logic [smm_pkg::STATUS_W-1:0]       rsp_status
);
   import smm_pkg::*;

   logic [CNT_W-1:0]        first_count_ff, first_count_in;
   logic [CNT_W-1:0]        second_count_ff, second_count_in;
   logic                    dropped_ff, dropped_in;
   logic                    busy_ff, busy_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [MED_W-1:0] median_ff, median_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic                    accept;
   logic                    wr_first, wr_second;
   logic                    walk_start;
   walk_cmd_type            walk_cmd;
   walk_rsp_type            walk_rsp;
   logic [TOT_W-1:0]        total;
   logic [CNT_W-1:0]        hi_pos;
   logic [ADDR_W-1:0]       rd_addr_first, rd_addr_second;
   logic signed [VALUE_W-1:0] rd_data_first, rd_data_second;

   assign req_ready = !busy_ff && ((req_mode != MODE_QUERY) || !rsp_valid_ff);
   assign accept    = req_valid && req_ready;

   assign total  = {1'b0, first_count_ff} + {1'b0, second_count_ff};
   assign hi_pos = total[TOT_W-1:1];

   assign walk_cmd.first_count  = first_count_ff;
   assign walk_cmd.second_count = second_count_ff;
   assign walk_cmd.hi_pos       = hi_pos;
   // for an odd total both picks are the middle element, so the sum is always lo + hi
   assign walk_cmd.lo_pos       = total[0] ? hi_pos : hi_pos - CNT_W'(1);

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      busy_in         = busy_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      median_in       = median_ff;
      status_in       = status_ff;
      wr_first        = 1'b0;
      wr_second       = 1'b0;
      walk_start      = 1'b0;

      if (accept) begin
         unique case (req_mode)
            MODE_FIRST: begin
               if (first_count_ff < CNT_W'(LIST_DEPTH)) begin
                  wr_first       = 1'b1;
                  first_count_in = first_count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            MODE_SECOND: begin
               if (second_count_ff < CNT_W'(LIST_DEPTH)) begin
                  wr_second       = 1'b1;
                  second_count_in = second_count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            MODE_QUERY: begin
               first_count_in  = '0;
               second_count_in = '0;
               dropped_in      = 1'b0;
               if (dropped_ff) begin
                  rsp_valid_in = 1'b1;
                  median_in    = '0;
                  status_in    = STATUS_DROPPED;
               end else if (total == '0) begin
                  rsp_valid_in = 1'b1;
                  median_in    = '0;
                  status_in    = STATUS_EMPTY;
               end else begin
                  walk_start = 1'b1;
                  busy_in    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (walk_rsp.done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         median_in    = {walk_rsp.lo[VALUE_W-1], walk_rsp.lo}
                      + {walk_rsp.hi[VALUE_W-1], walk_rsp.hi};
         status_in    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         busy_ff         <= busy_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      median_ff <= median_in;
      status_ff <= status_in;
   end

   smm_list_ram u_first_ram (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (first_count_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr_first),
      .rd_data (rd_data_first)
   );

   smm_list_ram u_second_ram (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (second_count_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr_second),
      .rd_data (rd_data_second)
   );

   smm_walker u_walker (
      .clock          (clock),
      .reset          (reset),
      .start          (walk_start),
      .cmd            (walk_cmd),
      .rd_addr_first  (rd_addr_first),
      .rd_addr_second (rd_addr_second),
      .rd_data_first  (rd_data_first),
      .rd_data_second (rd_data_second),
      .rsp            (walk_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_twice = median_ff;
   assign rsp_status       = status_ff;

   // a walk runs only with the result slot empty
   a_busy_slot: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && rsp_valid_ff))
      else $error("walk running while a result waits");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      walk_rsp.done |-> busy_ff)
      else $error("walk finished with no query in flight");

   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready)
      else $error("beat taken during a walk");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= CNT_W'(LIST_DEPTH)) && (second_count_ff <= CNT_W'(LIST_DEPTH)))
      else $error("list count beyond capacity");

endmodule

/* rtl/core/smm_list_ram.sv */
// one list store: single write port, single registered read port
module smm_list_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [smm_pkg::ADDR_W-1:0]        wr_addr,
   input  logic signed [smm_pkg::VALUE_W-1:0] wr_data,
   input  logic [smm_pkg::ADDR_W-1:0]        rd_addr,
   output logic signed [smm_pkg::VALUE_W-1:0] rd_data
);
   import smm_pkg::*;

   logic signed [VALUE_W-1:0] mem [LIST_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/smm_walker.sv */
// merge-order walk over both list memories, one element per cycle
module smm_walker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  smm_pkg::walk_cmd_type              cmd,
   output logic [smm_pkg::ADDR_W-1:0]         rd_addr_first,
   output logic [smm_pkg::ADDR_W-1:0]         rd_addr_second,
   input  logic signed [smm_pkg::VALUE_W-1:0] rd_data_first,
   input  logic signed [smm_pkg::VALUE_W-1:0] rd_data_second,
   output smm_pkg::walk_rsp_type              rsp
);
   import smm_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PRIME = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;

   logic [1:0]                state_ff, state_in;
   walk_cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]          a_ff, a_in;
   logic [CNT_W-1:0]          b_ff, b_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic signed [VALUE_W-1:0] lo_ff, lo_in;
   logic signed [VALUE_W-1:0] hi_ff, hi_in;
   logic                      done_ff, done_in;

   logic                      have_a, have_b, take_a;
   logic signed [VALUE_W-1:0] elem;

   assign have_a = a_ff < cmd_ff.first_count;
   assign have_b = b_ff < cmd_ff.second_count;
   // ties go to the second list
   assign take_a = have_a && (!have_b || (rd_data_first < rd_data_second));
   assign elem   = take_a ? rd_data_first : rd_data_second;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      pos_in   = pos_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            a_in   = '0;
            b_in   = '0;
            pos_in = '0;
            if (start) begin
               cmd_in   = cmd;
               state_in = S_PRIME;
            end
         end
         // heads at address zero are being read
         S_PRIME: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            if (take_a) begin
               a_in = a_ff + CNT_W'(1);
            end else begin
               b_in = b_ff + CNT_W'(1);
            end
            pos_in = pos_ff + CNT_W'(1);
            if (pos_ff == cmd_ff.lo_pos) begin
               lo_in = elem;
            end
            if (pos_ff == cmd_ff.hi_pos) begin
               hi_in    = elem;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // next index drives the address so the head is ready the following cycle
   assign rd_addr_first  = a_in[ADDR_W-1:0];
   assign rd_addr_second = b_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cmd_ff <= cmd_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      pos_ff <= pos_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

   assign rsp.done = done_ff;
   assign rsp.lo   = lo_ff;
   assign rsp.hi   = hi_ff;

endmodule
